[rtl/lav_pkg.sv]
package lav_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W = 32;
	localparam int IN_W = 9 * DATA_W;
	localparam int OUT_W = 136;
	// magnitude width into the normaliser, wide enough for the side vector
	localparam int CM = FRAC_BITS + 33;
	localparam int HM = (CM + 1) / 2;
	localparam int NW = 2 * CM + 2 * FRAC_BITS + 4;
	localparam int QB = FRAC_BITS + 1;
	localparam int WB = FRAC_BITS + 2;
	localparam int VB = FRAC_BITS + 3;
	localparam int DW = FRAC_BITS + 38;
	localparam int PW = WB + DATA_W;
	localparam int VW = VB + DATA_W;
	localparam logic [1:0] ROW_LAST = 2'd3;
	localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic [2:0][DATA_W-1:0] eye;
		logic [2:0][DATA_W-1:0] up;
		logic [2:0][WB-1:0] w;
		logic deg;
	} lav_side_t;

	// truncate toward zero by the fraction bits
	function automatic logic signed [DW-1:0] drop_frac(input logic signed [DW-1:0] s);
		logic [DW-1:0] m;
		m = s[DW-1] ? DW'(-s) : DW'(s);
		m = m >> FRAC_BITS;
		return s[DW-1] ? $signed(-m) : $signed(m);
	endfunction

	// negate the dropped dot product and clamp to the word range
	function automatic logic [DATA_W-1:0] neg_drop_sat(input logic signed [DW-1:0] s);
		logic signed [DW-1:0] d;
		d = -drop_frac(s);
		if (d[DW-1:DATA_W-1] == '0 || d[DW-1:DATA_W-1] == '1)
			return d[DATA_W-1:0];
		else
			return d[DW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
	endfunction

endpackage

[rtl/lav_norm.sv]
module lav_norm (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [2:0][lav_pkg::CM-1:0] in_mag,
	input logic [2:0] in_neg,
	input lav_pkg::lav_side_t in_side,
	output logic out_valid,
	output logic [2:0][lav_pkg::WB-1:0] out_vec,
	output logic out_nz,
	output lav_pkg::lav_side_t out_side
);
	import lav_pkg::*;

	localparam int NSTG = FRAC_BITS + 1;

	logic v_s1, v_s2;
	logic [2:0][2*HM-1:0] hh_s1, hl_s1, ll_s1;
	logic [2:0] neg_s1, neg_s2;
	lav_side_t side_s1, side_s2;
	logic [2:0][NW-1:0] sq_s2;

	logic it_v [0:NSTG];
	logic [2:0][NW-1:0] it_l [0:NSTG];
	logic [2:0][NW-1:0] it_p [0:NSTG];
	logic [2:0][NW-1:0] it_r [0:NSTG];
	logic [NW-1:0] it_s [0:NSTG];
	logic [2:0][QB-1:0] it_q [0:NSTG];
	logic [2:0] it_neg [0:NSTG];
	lav_side_t it_side [0:NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			it_v[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			it_v[0] <= v_s2;
		end
	end

	// split each square into half-width partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				hh_s1[k] <= (2*HM)'(in_mag[k][CM-1:HM]) * (2*HM)'(in_mag[k][CM-1:HM]);
				hl_s1[k] <= (2*HM)'(in_mag[k][CM-1:HM]) * (2*HM)'(in_mag[k][HM-1:0]);
				ll_s1[k] <= (2*HM)'(in_mag[k][HM-1:0]) * (2*HM)'(in_mag[k][HM-1:0]);
			end
			neg_s1 <= in_neg;
			side_s1 <= in_side;
			for (int k = 0; k < 3; k++)
				sq_s2[k] <= (NW'(hh_s1[k]) << (2*HM)) + (NW'(hl_s1[k]) << (HM+1))
					+ NW'(ll_s1[k]);
			neg_s2 <= neg_s1;
			side_s2 <= side_s1;
			it_s[0] <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			for (int k = 0; k < 3; k++) begin
				it_r[0][k] <= sq_s2[k] << (2*FRAC_BITS);
				it_l[0][k] <= '0;
				it_p[0][k] <= '0;
				it_q[0][k] <= '0;
			end
			it_neg[0] <= neg_s2;
			it_side[0] <= side_s2;
		end
	end

	// one quotient bit per stage: keep q*S and q*q*S as running sums
	for (genvar g = 0; g < NSTG; g++) begin : g_bit
		localparam int B = FRAC_BITS - g;
		logic [2:0][NW-1:0] lt;
		logic [2:0] tk;

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				lt[k] = it_l[g][k] + (it_p[g][k] << (B+1)) + (it_s[g] << (2*B));
				tk[k] = lt[k] <= it_r[g][k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				it_v[g+1] <= 1'b0;
			else if (en)
				it_v[g+1] <= it_v[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					it_l[g+1][k] <= tk[k] ? lt[k] : it_l[g][k];
					it_p[g+1][k] <= tk[k] ? it_p[g][k] + (it_s[g] << B) : it_p[g][k];
					it_q[g+1][k] <= tk[k] ? it_q[g][k] | (QB'(1) << B) : it_q[g][k];
					it_r[g+1][k] <= it_r[g][k];
				end
				it_s[g+1] <= it_s[g];
				it_neg[g+1] <= it_neg[g];
				it_side[g+1] <= it_side[g];
			end
		end
	end

	assign out_valid = it_v[NSTG];
	assign out_nz = it_s[NSTG] != '0;
	assign out_side = it_side[NSTG];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (!out_nz)
				out_vec[k] = '0;
			else if (it_neg[NSTG][k])
				out_vec[k] = -WB'(it_q[NSTG][k]);
			else
				out_vec[k] = WB'(it_q[NSTG][k]);
		end
	end

endmodule

[rtl/look_at_view_matrix.sv]
// Look-at view matrix engine.
// Input stream s_*: one word per camera, nine signed Q16.16 values
// (eye, target, up). Output stream m_*: four words per camera, rows 0..3
// of the view matrix; m_tlast marks row 3, m_tuser flags a degenerate
// camera (eye on target, or up parallel to the view axis), whose rows 0..2
// are zero while row 3 stays [0,0,0,1].
// Pipeline (Q16.16 at FRAC_BITS = 16): one input stage, two exact normalisers
// of FRAC_BITS+4 stages each (two squaring stages, a sum stage, one stage per
// quotient bit), two cross product stages and four product/dot stages.
// Throughput: set by the output port, which moves one row per cycle while
// m_tready is high; the pipeline takes a word per cycle when not stalled.
// The final stage hands its camera to an output holding register, so a
// new camera is loaded while row 3 of the previous one is taken.
// A stall with v_p4 set freezes every stage; nothing is lost or repeated.
// Reset clears all valid bits; no word is presented until new input.
module look_at_view_matrix (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// eye_x, eye_y, eye_z, target_x, target_y, target_z, upward_x, upward_y, upward_z
	input logic [lav_pkg::IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// row_index[1:0], col0[33:2], col1[65:34], col2[97:66], col3[129:98], zero pad
	output logic [lav_pkg::OUT_W-1:0] m_tdata,
	// degenerate
	output logic m_tuser,
	output logic m_tlast
);
	import lav_pkg::*;

	logic en, take;

	// input stage
	logic v_s1;
	logic [2:0][DATA_W-1:0] eye_s1, up_s1;
	logic [2:0][CM-1:0] dmag_s1;
	logic [2:0] dneg_s1;
	lav_side_t side1;

	// forward normaliser
	logic n1_v, n1_nz;
	logic [2:0][WB-1:0] n1_w;
	lav_side_t n1_side;

	// side vector cross product
	logic vx_s1, vx_s2;
	logic signed [PW-1:0] cp_s1 [6];
	lav_side_t sx_s1, sx_s2;
	logic [2:0][CM-1:0] cmag_s2;
	logic [2:0] cneg_s2;

	// side normaliser
	logic n2_v, n2_nz;
	logic [2:0][WB-1:0] n2_u;
	lav_side_t n2_side;

	// rows and translation terms
	logic v_p1, v_p2, v_p3, v_p4;
	logic signed [2*WB-1:0] wu_p1 [6];
	logic signed [PW-1:0] ue_p1 [3], we_p1 [3];
	logic [2:0][WB-1:0] u_p1, w_p1, u_p2, w_p2, u_p3, w_p3, u_p4, w_p4;
	logic [2:0][DATA_W-1:0] eye_p1, eye_p2;
	logic deg_p1, deg_p2, deg_p3, deg_p4;
	logic [2:0][VB-1:0] v_vec_p2, v_vec_p3, v_vec_p4;
	logic [DATA_W-1:0] tu_p2, tw_p2, tu_p3, tw_p3, tu_p4, tw_p4, tv_p4;
	logic signed [VW-1:0] ve_p3 [3];

	// output holding register
	logic hold_q, deg_q;
	logic [1:0] row_q;
	logic [3:0][3:0][DATA_W-1:0] mat_q;
	logic [3:0][3:0][DATA_W-1:0] mat_d;

	assign take = v_p4 && (!hold_q || (m_tready && row_q == ROW_LAST));
	assign en = !v_p4 || take;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vx_s1 <= 1'b0;
			vx_s2 <= 1'b0;
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
			v_p4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			vx_s1 <= n1_v;
			vx_s2 <= vx_s1;
			v_p1 <= n2_v;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			v_p4 <= v_p3;
		end
	end

	// form eye - target exactly and split into sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [DATA_W:0] d;
				d = $signed(s_tdata[DATA_W*k +: DATA_W])
					- $signed(s_tdata[DATA_W*(k+3) +: DATA_W]);
				eye_s1[k] <= s_tdata[DATA_W*k +: DATA_W];
				up_s1[k] <= s_tdata[DATA_W*(k+6) +: DATA_W];
				dneg_s1[k] <= d[DATA_W];
				dmag_s1[k] <= CM'(d[DATA_W] ? (DATA_W+1)'(-d) : (DATA_W+1)'(d));
			end
		end
	end

	always_comb begin
		side1.eye = eye_s1;
		side1.up = up_s1;
		side1.w = '0;
		side1.deg = 1'b0;
	end

	lav_norm u_norm_fwd (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s1),
		.in_mag(dmag_s1),
		.in_neg(dneg_s1),
		.in_side(side1),
		.out_valid(n1_v),
		.out_vec(n1_w),
		.out_nz(n1_nz),
		.out_side(n1_side)
	);

	// c = cross(-w, up): products first, differences next
	always_ff @(posedge clk) begin
		if (en) begin
			cp_s1[0] <= $signed(n1_w[2]) * $signed(n1_side.up[1]);
			cp_s1[1] <= $signed(n1_w[1]) * $signed(n1_side.up[2]);
			cp_s1[2] <= $signed(n1_w[0]) * $signed(n1_side.up[2]);
			cp_s1[3] <= $signed(n1_w[2]) * $signed(n1_side.up[0]);
			cp_s1[4] <= $signed(n1_w[1]) * $signed(n1_side.up[0]);
			cp_s1[5] <= $signed(n1_w[0]) * $signed(n1_side.up[1]);
			sx_s1.eye <= n1_side.eye;
			sx_s1.up <= n1_side.up;
			sx_s1.w <= n1_w;
			sx_s1.deg <= !n1_nz;
			for (int k = 0; k < 3; k++) begin
				logic signed [DW-1:0] c;
				c = DW'(cp_s1[2*k]) - DW'(cp_s1[2*k+1]);
				cneg_s2[k] <= c[DW-1];
				cmag_s2[k] <= c[DW-1] ? CM'(-c) : CM'(c);
			end
			sx_s2 <= sx_s1;
		end
	end

	lav_norm u_norm_side (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vx_s2),
		.in_mag(cmag_s2),
		.in_neg(cneg_s2),
		.in_side(sx_s2),
		.out_valid(n2_v),
		.out_vec(n2_u),
		.out_nz(n2_nz),
		.out_side(n2_side)
	);

	// products for v = cross(w, u) and the u and w dot products with eye
	always_ff @(posedge clk) begin
		if (en) begin
			wu_p1[0] <= $signed(n2_side.w[1]) * $signed(n2_u[2]);
			wu_p1[1] <= $signed(n2_side.w[2]) * $signed(n2_u[1]);
			wu_p1[2] <= $signed(n2_side.w[2]) * $signed(n2_u[0]);
			wu_p1[3] <= $signed(n2_side.w[0]) * $signed(n2_u[2]);
			wu_p1[4] <= $signed(n2_side.w[0]) * $signed(n2_u[1]);
			wu_p1[5] <= $signed(n2_side.w[1]) * $signed(n2_u[0]);
			for (int k = 0; k < 3; k++) begin
				ue_p1[k] <= $signed(n2_u[k]) * $signed(n2_side.eye[k]);
				we_p1[k] <= $signed(n2_side.w[k]) * $signed(n2_side.eye[k]);
			end
			u_p1 <= n2_u;
			w_p1 <= n2_side.w;
			eye_p1 <= n2_side.eye;
			deg_p1 <= n2_side.deg | !n2_nz;
		end
	end

	// v truncated toward zero; close the u and w translation terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [DW-1:0] vd;
				vd = drop_frac(DW'(wu_p1[2*k]) - DW'(wu_p1[2*k+1]));
				v_vec_p2[k] <= vd[VB-1:0];
			end
			tu_p2 <= neg_drop_sat(DW'(ue_p1[0]) + DW'(ue_p1[1]) + DW'(ue_p1[2]));
			tw_p2 <= neg_drop_sat(DW'(we_p1[0]) + DW'(we_p1[1]) + DW'(we_p1[2]));
			u_p2 <= u_p1;
			w_p2 <= w_p1;
			eye_p2 <= eye_p1;
			deg_p2 <= deg_p1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++)
				ve_p3[k] <= $signed(v_vec_p2[k]) * $signed(eye_p2[k]);
			v_vec_p3 <= v_vec_p2;
			u_p3 <= u_p2;
			w_p3 <= w_p2;
			tu_p3 <= tu_p2;
			tw_p3 <= tw_p2;
			deg_p3 <= deg_p2;
			tv_p4 <= neg_drop_sat(DW'(ve_p3[0]) + DW'(ve_p3[1]) + DW'(ve_p3[2]));
			v_vec_p4 <= v_vec_p3;
			u_p4 <= u_p3;
			w_p4 <= w_p3;
			tu_p4 <= tu_p3;
			tw_p4 <= tw_p3;
			deg_p4 <= deg_p3;
		end
	end

	// hold one camera and step through its four rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			row_q <= '0;
		end else if (take) begin
			hold_q <= 1'b1;
			row_q <= '0;
		end else if (hold_q && m_tready) begin
			if (row_q == ROW_LAST)
				hold_q <= 1'b0;
			row_q <= row_q + 2'd1;
		end
	end

	// assemble the four rows; zero the first three for a degenerate camera
	always_comb begin
		mat_d = '0;
		if (!deg_p4) begin
			for (int k = 0; k < 3; k++) begin
				mat_d[0][k] = DATA_W'($signed(u_p4[k]));
				mat_d[1][k] = DATA_W'($signed(v_vec_p4[k]));
				mat_d[2][k] = DATA_W'($signed(w_p4[k]));
			end
			mat_d[0][3] = tu_p4;
			mat_d[1][3] = tv_p4;
			mat_d[2][3] = tw_p4;
		end
		mat_d[3][3] = ONE_Q;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			deg_q <= deg_p4;
			mat_q <= mat_d;
		end
	end

	assign m_tvalid = hold_q;
	assign m_tdata = {6'b0, mat_q[row_q][3], mat_q[row_q][2], mat_q[row_q][1],
		mat_q[row_q][0], row_q};
	assign m_tuser = deg_q;
	assign m_tlast = row_q == ROW_LAST;

`ifndef ASSERT_OFF
	// rows of one camera leave without gaps once the first is taken
	a_rows_packed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("row burst broken");

	// rows count up by one within a camera
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1)
		else $error("row index skipped");

	// the closing row is always the homogeneous unit row
	a_last_unit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[129:98] == ONE_Q && m_tdata[97:2] == '0)
		else $error("bad closing row");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
	import lav_pkg::*;

	localparam int FB = FRAC_BITS;
	localparam int SETTLE = 2 * FRAC_BITS + 40;

	typedef logic signed [63:0] trio_t [0:2];

	// one camera word: eye, target, up
	typedef struct {
		logic [31:0] eye [0:2];
		logic [31:0] tgt [0:2];
		logic [31:0] up [0:2];
	} camera_t;

	// one matrix row as it leaves the block
	typedef struct packed {
		logic [1:0] row;
		logic [31:0] c0;
		logic [31:0] c1;
		logic [31:0] c2;
		logic [31:0] c3;
		logic deg;
		logic last;
	} mat_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	mat_row_t pending_rows [$];
	int sender_idle_pct;
	int receiver_stall_pct;
	int errors;
	int cameras_sent;
	int rows_seen;
	int degenerate_seen;

	look_at_view_matrix uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// exact unit vector, quotient truncated toward zero; 0 when the vector is zero
	function automatic bit unit_vec(input trio_t vin, output trio_t res);
		logic [255:0] sum;
		logic [255:0] rhs;
		logic [255:0] lhs;
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] cand;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			m = vin[i] < 0 ? -vin[i] : vin[i];
			sum += 256'(m) * 256'(m);
		end
		for (int i = 0; i < 3; i++)
			res[i] = 0;
		if (sum == 0)
			return 1'b0;
		for (int i = 0; i < 3; i++) begin
			m = vin[i] < 0 ? -vin[i] : vin[i];
			rhs = (256'(m) * 256'(m)) << (2 * FB);
			q = 0;
			for (int b = FB; b >= 0; b--) begin
				cand = q | (64'd1 << b);
				lhs = 256'(cand * cand) * sum;
				if (lhs <= rhs)
					q = cand;
			end
			res[i] = vin[i] < 0 ? -$signed(q) : $signed(q);
		end
		return 1'b1;
	endfunction

	function automatic logic signed [63:0] trunc_frac(input logic signed [63:0] x);
		logic [63:0] m;
		m = x < 0 ? -x : x;
		m = m >> FB;
		return x < 0 ? -$signed(m) : $signed(m);
	endfunction

	// translation term: minus the dot with the eye, clamped to the word range
	function automatic logic [31:0] translation(input trio_t a, input trio_t e);
		logic signed [63:0] d;
		d = -trunc_frac(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
		if (d > 64'sd2147483647)
			d = 64'sd2147483647;
		if (d < -64'sd2147483648)
			d = -64'sd2147483648;
		return d[31:0];
	endfunction

	// work out the four rows for one camera and queue them
	task automatic queue_view_rows(input camera_t cam);
		trio_t eye, dir, up, w, c, u, v;
		logic [31:0] mat [0:3][0:3];
		bit ok;
		mat_row_t r;
		for (int i = 0; i < 3; i++) begin
			eye[i] = 64'($signed(cam.eye[i]));
			dir[i] = eye[i] - 64'($signed(cam.tgt[i]));
			up[i] = 64'($signed(cam.up[i]));
		end
		for (int k = 0; k < 4; k++)
			for (int i = 0; i < 4; i++)
				mat[k][i] = '0;
		ok = unit_vec(dir, w);
		if (ok) begin
			c[0] = -(w[1] * up[2] - w[2] * up[1]);
			c[1] = -(w[2] * up[0] - w[0] * up[2]);
			c[2] = -(w[0] * up[1] - w[1] * up[0]);
			ok = unit_vec(c, u);
		end
		if (ok) begin
			v[0] = trunc_frac(w[1] * u[2] - w[2] * u[1]);
			v[1] = trunc_frac(w[2] * u[0] - w[0] * u[2]);
			v[2] = trunc_frac(w[0] * u[1] - w[1] * u[0]);
			for (int i = 0; i < 3; i++) begin
				mat[0][i] = u[i][31:0];
				mat[1][i] = v[i][31:0];
				mat[2][i] = w[i][31:0];
			end
			mat[0][3] = translation(u, eye);
			mat[1][3] = translation(v, eye);
			mat[2][3] = translation(w, eye);
		end
		mat[3][3] = 32'd1 << FB;
		for (int k = 0; k < 4; k++) begin
			r.row = 2'(k);
			r.c0 = mat[k][0];
			r.c1 = mat[k][1];
			r.c2 = mat[k][2];
			r.c3 = mat[k][3];
			r.deg = !ok;
			r.last = (2'(k) == ROW_LAST);
			pending_rows.push_back(r);
		end
	endtask

	// present one camera word, hold it until taken
	task automatic send_camera(input camera_t cam);
		logic [IN_W-1:0] word;
		for (int i = 0; i < 3; i++) begin
			word[32*i +: 32] = cam.eye[i];
			word[32*(3+i) +: 32] = cam.tgt[i];
			word[32*(6+i) +: 32] = cam.up[i];
		end
		if ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		queue_view_rows(cam);
		cameras_sent++;
	endtask

	// drop valid and hold off until every row has come back
	task automatic drain_rows;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic camera_t make_camera(input logic [31:0] ex, ey, ez, tx, ty, tz,
			ux, uy, uz);
		camera_t cam;
		cam.eye[0] = ex; cam.eye[1] = ey; cam.eye[2] = ez;
		cam.tgt[0] = tx; cam.tgt[1] = ty; cam.tgt[2] = tz;
		cam.up[0] = ux; cam.up[1] = uy; cam.up[2] = uz;
		return cam;
	endfunction

	// small Q16.16 value within about +/- 16.0
	function automatic logic [31:0] near_val;
		return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
	endfunction

	// plain cameras, eye on target, up along the view axis or zero, extremes
	task automatic test_directed;
		logic [31:0] one, mx, mn;
		one = 32'd1 << FB;
		mx = 32'h7fff_ffff;
		mn = 32'h8000_0000;
		send_camera(make_camera(0, 0, 5 * one, 0, 0, 0, 0, one, 0));
		send_camera(make_camera(one, 2 * one, 3 * one, -one, 0, 0, 0, 0, one));
		send_camera(make_camera(3 * one, 3 * one, 3 * one, 3 * one, 3 * one, 3 * one,
			0, one, 0));
		send_camera(make_camera(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_camera(make_camera(0, 0, 4 * one, 0, 0, 0, 0, 0, one));
		send_camera(make_camera(0, 0, 4 * one, 0, 0, 0, 0, 0, -7 * one));
		send_camera(make_camera(one, 0, 0, 0, 0, 0, 0, 0, 0));
		send_camera(make_camera(mx, mx, mx, mn, mn, mn, 0, one, 0));
		send_camera(make_camera(mn, mn, mn, mx, mx, mx, mn, mx, mn));
		send_camera(make_camera(mx, 0, 0, 0, 0, 0, 0, mx, 0));
		send_camera(make_camera(mn, 0, 0, 0, 0, 0, 0, mn, 0));
		send_camera(make_camera(mx, mx, mx, 0, 0, 0, mn, mx, 0));
		send_camera(make_camera(mn, mn, mn, mx, mx, mx, 1, 0, 0));
		send_camera(make_camera(mx, mn, mx, mn, mx, mn, mx, mx, mx));
		send_camera(make_camera(1, 0, 0, 0, 0, 0, 0, 1, 0));
		send_camera(make_camera(0, -1, 0, 0, 0, 0, 0, 0, -1));
		send_camera(make_camera(mx, mx, mx, mx, mx, mx - 1, 32'hffff_ffff, 0, 0));
		send_camera(make_camera(0, 0, 0, one, one, one, 0, one, 0));
		// up parallel but opposite and scaled
		send_camera(make_camera(2 * one, 2 * one, 0, 0, 0, 0, -one, -one, 0));
	endtask

	// mostly well-scaled cameras, some full-range words, a few degenerate ones
	task automatic test_random(input int count);
		camera_t cam;
		int kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(99);
			for (int i = 0; i < 3; i++) begin
				if (kind < 25) begin
					cam.eye[i] = $urandom;
					cam.tgt[i] = $urandom;
					cam.up[i] = $urandom;
				end else begin
					cam.eye[i] = near_val();
					cam.tgt[i] = near_val();
					cam.up[i] = near_val();
				end
			end
			if (kind >= 90 && kind < 95)
				cam.tgt = cam.eye;
			if (kind >= 95)
				for (int i = 0; i < 3; i++)
					cam.up[i] = cam.eye[i] - cam.tgt[i];
			send_camera(cam);
		end
	endtask

	// one phase of random traffic per idling mix
	task automatic test_idle_mix(input int idle_pct, input int stall_pct, input int count);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		test_random(count);
	endtask

	// receiver back-pressure, changed at the falling edge
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);

	// compare each row taken with the oldest one waiting
	always @(posedge clk) begin
		mat_row_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.row = m_tdata[1:0];
			got.c0 = m_tdata[33:2];
			got.c1 = m_tdata[65:34];
			got.c2 = m_tdata[97:66];
			got.c3 = m_tdata[129:98];
			got.deg = m_tuser;
			got.last = m_tlast;
			rows_seen++;
			if (pending_rows.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("row with nothing waiting: %p", got);
			end else begin
				want = pending_rows.pop_front();
				if (want.deg && want.last)
					degenerate_seen++;
				if (got !== want) begin
					errors++;
					if (errors <= 10) begin
						$display("row mismatch at %0t", $realtime);
						$display("  expected %p", want);
						$display("  actual   %p", got);
					end
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("timeout, %0d rows still waiting", pending_rows.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		errors = 0;
		cameras_sent = 0;
		rows_seen = 0;
		degenerate_seen = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		drain_rows();
		test_idle_mix(0, 0, 25);
		test_idle_mix(52, 0, 25);
		drain_rows();
		test_idle_mix(0, 52, 25);
		test_idle_mix(33, 33, 25);
		drain_rows();

		if (pending_rows.size() != 0)
			errors++;
		$display("%0d cameras sent, %0d rows checked, %0d degenerate cameras,", cameras_sent,
			rows_seen, degenerate_seen);
		$display("idle mixes none, sender 52%%, receiver 52%%, both 33%%; %0d errors", errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[look_at_view_matrix.f]
rtl/lav_pkg.sv
rtl/lav_norm.sv
rtl/look_at_view_matrix.sv
sim/tb.sv
